### hdl/barometric_pressure_compensation_macros.svh
// assertion macros for the barometric pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// same-cycle implication under reset
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bpc_pkg.sv
// shared types and constants for the barometric pressure compensation block
package bpc_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int RAW_W   = 24;
	localparam int COEFF_W = 16;
	localparam int TEMP_W  = 15;
	localparam int PRES_W  = 17;
	localparam int INDEX_W = 3;

	localparam int TEMP_LOW      = 2000;
	localparam int TEMP_VERY_LOW = -1500;
	localparam int T_MIN         = -4000;
	localparam int T_MAX         = 8500;
	localparam int P_MIN         = 1000;
	localparam int P_MAX         = 120000;

	typedef enum logic [INDEX_W-1:0] {
		REG_SENS     = 3'd0,
		REG_OFF      = 3'd1,
		REG_TCS      = 3'd2,
		REG_TCO      = 3'd3,
		REG_TREF     = 3'd4,
		REG_TEMPSENS = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [COEFF_W-1:0] sens;
		logic [COEFF_W-1:0] off;
		logic [COEFF_W-1:0] tcs;
		logic [COEFF_W-1:0] tco;
		logic [COEFF_W-1:0] tref;
		logic [COEFF_W-1:0] tempsens;
	} coeff_t;

	// first-order results and range class handed from front to back
	typedef struct packed {
		logic [RAW_W-1:0]   d1;
		logic signed [18:0] temp;
		logic [17:0]        t2;
		logic signed [35:0] off;
		logic signed [34:0] sens;
		logic               low;
		logic               very_low;
	} work_t;

endpackage

### hdl/bpc_front.sv
// front pipeline: accepts conversion pairs, first-order terms and range class
module bpc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bpc_pkg::coeff_t                   coeff,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bpc_pkg::RAW_W-1:0]         raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]         raw_temperature,
	input  logic                              q_full,
	output logic                              f_valid,
	output bpc_pkg::work_t                    f_item
);

	logic rdy1, rdy2, rdy3;

	logic                      v_s1, v_s2, v_s3;
	logic [bpc_pkg::RAW_W-1:0] d1_s1, d1_s2;
	logic signed [24:0]        dt_s1;
	logic signed [41:0]        tmul_s2, offmul_s2, sensmul_s2;
	logic signed [49:0]        dtsq_s2;
	bpc_pkg::work_t            item_s3;

	logic signed [24:0] dt_w;
	logic signed [41:0] tmul_w, offmul_w, sensmul_w;
	logic signed [49:0] dtsq_w;
	logic signed [18:0] temp_w;
	logic signed [35:0] off_w;
	logic signed [34:0] sens_w;

	assign rdy3     = !v_s3 || !q_full;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign f_valid  = v_s3;
	assign f_item   = item_s3;

	assign dt_w = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.tref, 8'h00});

	assign tmul_w    = dt_s1 * $signed({1'b0, coeff.tempsens});
	assign offmul_w  = dt_s1 * $signed({1'b0, coeff.tco});
	assign sensmul_w = dt_s1 * $signed({1'b0, coeff.tcs});
	assign dtsq_w    = dt_s1 * dt_s1;

	assign temp_w = $signed(tmul_s2[41:23]) + 19'(bpc_pkg::TEMP_LOW);
	assign off_w  = $signed({4'h0, coeff.off, 16'h0000}) + $signed(offmul_s2[41:7]);
	assign sens_w = $signed({4'h0, coeff.sens, 15'h0000}) + $signed(sensmul_s2[41:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= dt_w;
		end
		if (rdy2) begin
			d1_s2      <= d1_s1;
			tmul_s2    <= tmul_w;
			offmul_s2  <= offmul_w;
			sensmul_s2 <= sensmul_w;
			dtsq_s2    <= dtsq_w;
		end
		if (rdy3) begin
			item_s3.d1       <= d1_s2;
			item_s3.temp     <= temp_w;
			item_s3.t2       <= dtsq_s2[48:31];
			item_s3.off      <= off_w;
			item_s3.sens     <= sens_w;
			item_s3.low      <= temp_w < bpc_pkg::TEMP_LOW;
			item_s3.very_low <= temp_w < bpc_pkg::TEMP_VERY_LOW;
		end
	end

endmodule

### hdl/bpc_queue.sv
// short first-in first-out queue between front and back
module bpc_queue #(
	parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpc_pkg::work_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output bpc_pkg::work_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bpc_pkg::work_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign nonempty = count_q != '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

### hdl/bpc_back.sv
// back pipeline: second-order correction, pressure product and saturation
module bpc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  bpc_pkg::work_t                    q_item,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bpc_pkg::TEMP_W-1:0] temperature,
	output logic [bpc_pkg::PRES_W-1:0]        pressure,
	output logic                              out_of_range
);

	logic rdy1, rdy2, rdy3, rdy4, rdy_o;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;

	logic signed [19:0]        tcomp_s1;
	logic [35:0]               a2_s1, b2_s1;
	logic signed [35:0]        off_s1;
	logic signed [34:0]        sens_s1;
	logic [bpc_pkg::RAW_W-1:0] d1_s1, d1_s2;
	logic                      low_s1, vlow_s1;

	logic signed [40:0]               offc_s2, sensc_s2, offc_s3;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s2, temp_s3, temp_s4, temperature_q;
	logic                             tflag_s2, tflag_s3, tflag_s4, flag_q;

	logic [44:0]        plo_s3;
	logic signed [44:0] phi_s3;
	logic signed [46:0] diff_s4;
	logic [bpc_pkg::PRES_W-1:0] pressure_q;

	logic signed [19:0] a_w, b_w, tcomp_w;
	logic signed [39:0] asq_w, bsq_w;
	logic [38:0]        five_a2, seven_b2, eleven_b2, off2, sens2;
	logic signed [40:0] offc_w, sensc_w;
	logic [44:0]        plo_w;
	logic signed [44:0] phi_w;
	logic signed [46:0] diff_w;
	logic signed [31:0] pval;

	assign rdy_o = !out_valid_q || !out_stall;
	assign rdy4  = !v_s4 || rdy_o;
	assign rdy3  = !v_s3 || rdy4;
	assign rdy2  = !v_s2 || rdy3;
	assign rdy1  = !v_s1 || rdy2;
	assign pop   = q_valid && rdy1;

	assign out_valid    = out_valid_q;
	assign temperature  = temperature_q;
	assign pressure     = pressure_q;
	assign out_of_range = flag_q;

	// squares of the temperature deficits and the corrected temperature
	assign a_w     = {q_item.temp[18], q_item.temp} - 20'(bpc_pkg::TEMP_LOW);
	assign b_w     = {q_item.temp[18], q_item.temp} - 20'(bpc_pkg::TEMP_VERY_LOW);
	assign asq_w   = a_w * a_w;
	assign bsq_w   = b_w * b_w;
	assign tcomp_w = {q_item.temp[18], q_item.temp}
		- (q_item.low ? $signed({2'b00, q_item.t2}) : 20'sd0);

	// second-order offset and sensitivity corrections
	assign five_a2   = {3'b000, a2_s1} + {1'b0, a2_s1, 2'b00};
	assign seven_b2  = {b2_s1, 3'b000} - {3'b000, b2_s1};
	assign eleven_b2 = {b2_s1, 3'b000} + {2'b00, b2_s1, 1'b0} + {3'b000, b2_s1};
	assign off2  = low_s1 ? ({1'b0, five_a2[38:1]} + (vlow_s1 ? seven_b2 : 39'd0)) : 39'd0;
	assign sens2 = low_s1 ? ({2'b00, five_a2[38:2]}
		+ (vlow_s1 ? {1'b0, eleven_b2[38:1]} : 39'd0)) : 39'd0;
	assign offc_w  = off_s1 - $signed({2'b00, off2});
	assign sensc_w = sens_s1 - $signed({2'b00, sens2});

	// d1 * sens split at bit 21 so the low product folds into the shift
	assign plo_w  = d1_s2 * sensc_s2[20:0];
	assign phi_w  = $signed({1'b0, d1_s2}) * $signed(sensc_s2[40:21]);
	assign diff_w = phi_s3 + $signed({1'b0, plo_s3[44:21]}) - offc_s3;
	assign pval   = $signed(diff_s4[46:15]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= q_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
			if (rdy4)
				v_s4 <= v_s3;
			if (rdy_o)
				out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			tcomp_s1 <= tcomp_w;
			a2_s1    <= asq_w[35:0];
			b2_s1    <= bsq_w[35:0];
			off_s1   <= q_item.off;
			sens_s1  <= q_item.sens;
			d1_s1    <= q_item.d1;
			low_s1   <= q_item.low;
			vlow_s1  <= q_item.very_low;
		end
		if (rdy2) begin
			offc_s2  <= offc_w;
			sensc_s2 <= sensc_w;
			d1_s2    <= d1_s1;
			if (tcomp_s1 < bpc_pkg::T_MIN) begin
				temp_s2  <= bpc_pkg::TEMP_W'(bpc_pkg::T_MIN);
				tflag_s2 <= 1'b1;
			end else if (tcomp_s1 > bpc_pkg::T_MAX) begin
				temp_s2  <= bpc_pkg::TEMP_W'(bpc_pkg::T_MAX);
				tflag_s2 <= 1'b1;
			end else begin
				temp_s2  <= tcomp_s1[bpc_pkg::TEMP_W-1:0];
				tflag_s2 <= 1'b0;
			end
		end
		if (rdy3) begin
			plo_s3   <= plo_w;
			phi_s3   <= phi_w;
			offc_s3  <= offc_s2;
			temp_s3  <= temp_s2;
			tflag_s3 <= tflag_s2;
		end
		if (rdy4) begin
			diff_s4  <= diff_w;
			temp_s4  <= temp_s3;
			tflag_s4 <= tflag_s3;
		end
		if (rdy_o) begin
			temperature_q <= temp_s4;
			if (pval < bpc_pkg::P_MIN) begin
				pressure_q <= bpc_pkg::PRES_W'(bpc_pkg::P_MIN);
				flag_q     <= 1'b1;
			end else if (pval > bpc_pkg::P_MAX) begin
				pressure_q <= bpc_pkg::PRES_W'(bpc_pkg::P_MAX);
				flag_q     <= 1'b1;
			end else begin
				pressure_q <= pval[bpc_pkg::PRES_W-1:0];
				flag_q     <= tflag_s4;
			end
		end
	end

endmodule

### hdl/barometric_pressure_compensation.sv
// top level: calibration registers, front pipeline, queue and back pipeline
// an accepted item passes through the front pipeline, the queue, the back pipeline and the output register
// throughput: one item per cycle while out_stall is low, set by the pipelined multipliers in each half
// the queue lets the front keep taking items for a while when the output stalls
// reset clears all valid bits, the queue and the six coefficients to zero
module barometric_pressure_compensation #(
	parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bpc_pkg::INDEX_W-1:0]       cfg_index,
	input  logic [bpc_pkg::COEFF_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bpc_pkg::RAW_W-1:0]         raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]         raw_temperature,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bpc_pkg::TEMP_W-1:0] temperature,
	output logic [bpc_pkg::PRES_W-1:0]        pressure,
	output logic                              out_of_range
);

	bpc_pkg::coeff_t coeff_q;
	bpc_pkg::work_t  f_item, q_item;
	logic            f_valid, q_full, q_nonempty, q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bpc_pkg::REG_SENS:     coeff_q.sens     <= cfg_data;
				bpc_pkg::REG_OFF:      coeff_q.off      <= cfg_data;
				bpc_pkg::REG_TCS:      coeff_q.tcs      <= cfg_data;
				bpc_pkg::REG_TCO:      coeff_q.tco      <= cfg_data;
				bpc_pkg::REG_TREF:     coeff_q.tref     <= cfg_data;
				bpc_pkg::REG_TEMPSENS: coeff_q.tempsens <= cfg_data;
				default: ;
			endcase
		end
	end

	assign q_push = f_valid && !q_full;

	bpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coeff           (coeff_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.q_full          (q_full),
		.f_valid         (f_valid),
		.f_item          (f_item)
	);

	bpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_item  (q_item)
	);

	bpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_nonempty),
		.q_item       (q_item),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temperature  (temperature),
		.pressure     (pressure),
		.out_of_range (out_of_range)
	);

	`include "barometric_pressure_compensation_macros.svh"

	`BPC_ASSERT_NOW(a_result_in_range, out_valid, (temperature >= bpc_pkg::T_MIN) && (temperature <= bpc_pkg::T_MAX) && (pressure >= bpc_pkg::P_MIN) && (pressure <= bpc_pkg::P_MAX), "result outside saturation range")
	`BPC_ASSERT_NOW(a_flag_at_bound, out_valid && out_of_range, (temperature == bpc_pkg::T_MIN) || (temperature == bpc_pkg::T_MAX) || (pressure == bpc_pkg::P_MIN) || (pressure == bpc_pkg::P_MAX), "range flag without a clamped value")
	`BPC_ASSERT_NOW(a_queue_full_nonempty, q_full, q_nonempty, "queue full but empty")
	`BPC_ASSERT_NEXT(a_queue_fills, q_full && !q_pop, q_full, "full queue lost an item")

endmodule
